/* rtl/core/ceh_pkg.sv */
// ----------------------------------------------------------------------------
// ceh_pkg
// Shared types and constants for the two-lane exclusion hop block.
// ----------------------------------------------------------------------------
package ceh_pkg;

	localparam int OP_W    = 2;
	localparam int PICK_W  = 11;
	localparam int FRAC_W  = 16;
	localparam int DATA_W  = 64;
	localparam int THR_W   = 17;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [THR_W-1:0] THR_RESET = 17'h10000;

	typedef enum logic [OP_W-1:0] {
		OP_HOP  = 2'd0,
		OP_LOAD = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLR  = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_EXE  = 4'b0100,
		ST_WB   = 4'b1000
	} state_t;

endpackage

/* rtl/core/ceh_in_if.sv */
// ----------------------------------------------------------------------------
// ceh_in_if
// Request channel: operation, site pick, random fraction and load word.
// ----------------------------------------------------------------------------
interface ceh_in_if;
	logic                         valid;
	logic                         ready;
	logic [ceh_pkg::OP_W-1:0]     operation;
	logic [ceh_pkg::PICK_W-1:0]   site_pick;
	logic [ceh_pkg::FRAC_W-1:0]   random_fraction;
	logic [ceh_pkg::DATA_W-1:0]   load_bits;

	modport source (output valid, operation, site_pick, random_fraction, load_bits,
		input ready);
	modport sink (input valid, operation, site_pick, random_fraction, load_bits,
		output ready);
endinterface

/* rtl/core/ceh_out_if.sv */
// ----------------------------------------------------------------------------
// ceh_out_if
// Result channel: one 64-bit word per request.
// ----------------------------------------------------------------------------
interface ceh_out_if;
	logic                         valid;
	logic                         ready;
	logic [ceh_pkg::DATA_W-1:0]   result_bits;

	modport source (output valid, result_bits, input ready);
	modport sink (input valid, result_bits, output ready);
endinterface

/* rtl/core/ceh_lane_ram.sv */
// ----------------------------------------------------------------------------
// ceh_lane_ram
// Occupancy memory for one lane: port a read/write, port b read only,
// registered read data.
// ----------------------------------------------------------------------------
module ceh_lane_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic [AW-1:0] a_addr,
	input  logic          a_re,
	input  logic          a_we,
	input  logic [DW-1:0] a_wdata,
	output logic [DW-1:0] a_rdata,
	input  logic [AW-1:0] b_addr,
	input  logic          b_re,
	output logic [DW-1:0] b_rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (a_we) begin
			mem[a_addr] <= a_wdata;
		end
		if (a_re) begin
			a_rdata <= mem[a_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (b_re) begin
			b_rdata <= mem[b_addr];
		end
	end

endmodule

/* rtl/core/coupled_exclusion_hop_step.sv */
// ----------------------------------------------------------------------------
// coupled_exclusion_hop_step
// Two-lane exclusion hop update over a ring of sites for up to 64 replicas.
// ----------------------------------------------------------------------------
// Each lane's occupancy words sit in a memory of its own, read at the source
// and target sites together. A word takes three steps: read, write of the
// source word, write of the target word (held while the result register is
// full), since each memory takes one write a cycle; a load writes only the
// source word, a read nothing. A result register lets a new word in while the
// last result waits. After reset both memories are cleared, no word accepted.
// ----------------------------------------------------------------------------
module coupled_exclusion_hop_step #(
	parameter int SITES    = 1024,
	parameter int REPLICAS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ceh_in_if.sink                        in_ch,
	ceh_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ceh_pkg::PADDR_W-1:0]   paddr,
	input  logic [ceh_pkg::PDATA_W-1:0]   pwdata,
	output logic [ceh_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int SITE_W = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int CW     = (SITE_W + 2 > ceh_pkg::PICK_W) ? SITE_W + 2 : ceh_pkg::PICK_W;
	localparam logic [CW-1:0]     SITES_C = CW'(SITES);
	localparam logic [CW-1:0]     WORDS_C = CW'(2 * SITES);
	localparam logic [SITE_W-1:0] LAST_C  = SITE_W'(SITES - 1);

	// configuration
	logic [ceh_pkg::THR_W-1:0] thr_q;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : ceh_pkg::PDATA_W'(thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ceh_pkg::THR_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			thr_q <= pwdata[ceh_pkg::THR_W-1:0];
		end
	end

	// control
	ceh_pkg::state_t  state_q;
	logic [SITE_W-1:0] clr_q;
	logic              out_v_q;
	logic [ceh_pkg::DATA_W-1:0] out_q;
	logic              accept;
	logic              out_free;

	assign in_ch.ready       = (state_q == ceh_pkg::ST_IDLE);
	assign accept            = in_ch.valid && in_ch.ready;
	assign out_free          = !out_v_q || out_ch.ready;
	assign out_ch.valid      = out_v_q;
	assign out_ch.result_bits = out_q;

	// pick decode
	logic [CW-1:0]     pick_ext;
	logic              in_ok;
	logic              in_lane;
	logic [SITE_W-1:0] in_site;
	logic [SITE_W-1:0] in_dest;

	always_comb begin
		pick_ext = CW'(in_ch.site_pick);
		in_ok    = pick_ext < WORDS_C;
		in_lane  = pick_ext >= SITES_C;
		in_site  = in_lane ? SITE_W'(pick_ext - SITES_C) : SITE_W'(pick_ext);
		if (!in_lane) begin
			in_dest = (in_site == LAST_C) ? '0 : in_site + SITE_W'(1);
		end else begin
			in_dest = (in_site == '0) ? LAST_C : in_site - SITE_W'(1);
		end
	end

	// stage 1 registers
	ceh_pkg::op_t      op_s1;
	logic              ok_s1;
	logic              lane_s1;
	logic              cpl_s1;
	logic [SITE_W-1:0] site_s1;
	logic [SITE_W-1:0] dest_s1;
	logic [REPLICAS-1:0] load_s1;
	logic [REPLICAS-1:0] dnew_q;
	logic [ceh_pkg::DATA_W-1:0] res_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= ceh_pkg::op_t'(in_ch.operation);
			ok_s1   <= in_ok;
			lane_s1 <= in_lane;
			cpl_s1  <= {1'b0, in_ch.random_fraction} > thr_q;
			site_s1 <= in_site;
			dest_s1 <= in_dest;
			load_s1 <= in_ch.load_bits[REPLICAS-1:0];
		end
	end

	// memories
	logic [SITE_W-1:0]   a_addr;
	logic [SITE_W-1:0]   b_addr;
	logic                we0, we1;
	logic [REPLICAS-1:0] wdata;
	logic [REPLICAS-1:0] a0_rd, a1_rd, b0_rd, b1_rd;

	ceh_lane_ram #(.DEPTH(SITES), .AW(SITE_W), .DW(REPLICAS)) u_ram0 (
		.clk     (clk),
		.a_addr  (a_addr),
		.a_re    (accept),
		.a_we    (we0),
		.a_wdata (wdata),
		.a_rdata (a0_rd),
		.b_addr  (b_addr),
		.b_re    (accept),
		.b_rdata (b0_rd)
	);

	ceh_lane_ram #(.DEPTH(SITES), .AW(SITE_W), .DW(REPLICAS)) u_ram1 (
		.clk     (clk),
		.a_addr  (a_addr),
		.a_re    (accept),
		.a_we    (we1),
		.a_wdata (wdata),
		.a_rdata (a1_rd),
		.b_addr  (b_addr),
		.b_re    (accept),
		.b_rdata (b1_rd)
	);

	// hop datapath
	logic [REPLICAS-1:0] src, dst, osrc, odst, moved;
	logic                is_hop, is_load, is_read;

	always_comb begin
		src     = lane_s1 ? a1_rd : a0_rd;
		dst     = lane_s1 ? b1_rd : b0_rd;
		osrc    = lane_s1 ? a0_rd : a1_rd;
		odst    = lane_s1 ? b0_rd : b1_rd;
		moved   = src & ~dst;
		if (cpl_s1) begin
			moved = moved & ~(osrc & ~odst);
		end
		is_hop  = ok_s1 && (op_s1 == ceh_pkg::OP_HOP);
		is_load = ok_s1 && (op_s1 == ceh_pkg::OP_LOAD);
		is_read = ok_s1 && (op_s1 == ceh_pkg::OP_READ);
	end

	always_comb begin
		a_addr = in_site;
		b_addr = in_dest;
		we0    = 1'b0;
		we1    = 1'b0;
		wdata  = '0;
		case (state_q)
			ceh_pkg::ST_CLR: begin
				a_addr = clr_q;
				we0    = 1'b1;
				we1    = 1'b1;
			end
			ceh_pkg::ST_EXE: begin
				a_addr = site_s1;
				wdata  = is_load ? load_s1 : (src & ~moved);
				we0    = (is_hop || is_load) && !lane_s1;
				we1    = (is_hop || is_load) && lane_s1;
			end
			ceh_pkg::ST_WB: begin
				a_addr = dest_s1;
				wdata  = dnew_q;
				we0    = is_hop && !lane_s1 && out_free;
				we1    = is_hop && lane_s1 && out_free;
			end
			default: begin
				a_addr = in_site;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ceh_pkg::ST_EXE) begin
			dnew_q <= dst | moved;
			if (is_hop) begin
				res_q <= ceh_pkg::DATA_W'(moved);
			end else if (is_read) begin
				res_q <= ceh_pkg::DATA_W'(src);
			end else begin
				res_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ceh_pkg::ST_WB) && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ceh_pkg::ST_CLR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= ((state_q == ceh_pkg::ST_WB) && out_free) ||
				(out_v_q && !out_ch.ready);
			case (state_q)
				ceh_pkg::ST_CLR: begin
					clr_q <= clr_q + SITE_W'(1);
					if (clr_q == LAST_C) begin
						state_q <= ceh_pkg::ST_IDLE;
					end
				end
				ceh_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= ceh_pkg::ST_EXE;
					end
				end
				ceh_pkg::ST_EXE: begin
					state_q <= ceh_pkg::ST_WB;
				end
				ceh_pkg::ST_WB: begin
					if (out_free) begin
						state_q <= ceh_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ceh_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* bench/coupled_exclusion_hop_step_tb.sv */
// ----------------------------------------------------------------------------
// coupled_exclusion_hop_step_tb
// Self-checking bench for the two-lane exclusion hop block. A directed walk
// covers reset contents, ring wrap on both lanes, store extremes and the
// unused operation code. Random phases follow, one per coupling threshold
// setting: loads, hops, reads and unused codes, mostly near the ring seam.
// Each result word is checked against an occupancy model kept in the bench
// or, for some walk words, against a literal value. Both channels idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module coupled_exclusion_hop_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ceh_pkg::*;

	localparam int SITES        = 1024;
	localparam int REPLICAS     = 64;
	localparam int WORDS        = 2 * SITES;
	localparam int RUN_LIMIT    = 200000;
	localparam int PHASES       = 7;
	localparam int PHASE_WORDS  = 70;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [DATA_W-1:0]  LIVE_MASK = {DATA_W{1'b1}} >> (DATA_W - REPLICAS);
	localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = '0;

	localparam logic [THR_W-1:0] THR_STEPS [5] = '{
		17'd0, 17'h1FFFF, 17'd32768, 17'd65535, 17'h10000
	};
	localparam int RING_SEAM [5] = '{SITES - 2, SITES - 1, 0, 1, 2};

	typedef struct packed {
		op_t                op;
		logic [PICK_W-1:0]  pick;
		logic [FRAC_W-1:0]  frac;
		logic [DATA_W-1:0]  bits;
		logic               lit;
		logic [DATA_W-1:0]  want;
	} hop_word_t;

	localparam int WALK_LEN = 23;
	localparam hop_word_t WALK [WALK_LEN] = '{
		'{OP_READ, 11'd0,    16'h0000, 64'h0,                  1'b1, 64'h0},
		'{OP_READ, 11'd2047, 16'hFFFF, 64'hFFFFFFFFFFFFFFFF,   1'b1, 64'h0},
		'{OP_HOP,  11'd0,    16'h0000, 64'h0,                  1'b1, 64'h0},
		'{OP_LOAD, 11'd0,    16'h0000, 64'hFFFFFFFFFFFFFFFF,   1'b1, 64'h0},
		'{OP_LOAD, 11'd1,    16'h0000, 64'h00000000FFFFFFFF,   1'b1, 64'h0},
		'{OP_READ, 11'd0,    16'h0000, 64'h0,                  1'b1, 64'hFFFFFFFFFFFFFFFF},
		'{OP_HOP,  11'd0,    16'h0000, 64'h0,                  1'b0, 64'h0},
		'{OP_READ, 11'd0,    16'h0000, 64'h0,                  1'b0, 64'h0},
		'{OP_READ, 11'd1,    16'h0000, 64'h0,                  1'b0, 64'h0},
		'{OP_LOAD, 11'd1023, 16'h0000, 64'hFFFFFFFFFFFFFFFF,   1'b1, 64'h0},
		'{OP_HOP,  11'd1023, 16'hFFFF, 64'h0,                  1'b0, 64'h0},
		'{OP_READ, 11'd1023, 16'h0000, 64'h0,                  1'b0, 64'h0},
		'{OP_LOAD, 11'd1024, 16'h0000, 64'hAAAAAAAAAAAAAAAA,   1'b1, 64'h0},
		'{OP_HOP,  11'd1024, 16'd1234, 64'h0,                  1'b0, 64'h0},
		'{OP_READ, 11'd2047, 16'h0000, 64'h0,                  1'b0, 64'h0},
		'{OP_LOAD, 11'd1024, 16'h0000, 64'h5555555555555555,   1'b1, 64'h0},
		'{OP_LOAD, 11'd2047, 16'h0000, 64'h0F0F0F0F0F0F0F0F,   1'b1, 64'h0},
		'{OP_HOP,  11'd1024, 16'hFFFF, 64'h0,                  1'b0, 64'h0},
		'{OP_NONE, 11'd5,    16'hFFFF, 64'hFFFFFFFFFFFFFFFF,   1'b1, 64'h0},
		'{OP_NONE, 11'd2047, 16'h0000, 64'h0,                  1'b1, 64'h0},
		'{OP_READ, 11'd0,    16'h0000, 64'h0,                  1'b0, 64'h0},
		'{OP_LOAD, 11'd2047, 16'h0000, 64'h0,                  1'b1, 64'h0},
		'{OP_READ, 11'd1024, 16'h0000, 64'h0,                  1'b0, 64'h0}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	ceh_in_if  in_ch ();
	ceh_out_if out_ch ();

	logic [DATA_W-1:0]  lane_occ [WORDS];
	logic [THR_W-1:0]   gate_thr;
	logic [DATA_W-1:0]  want_bits_q [$];
	int                 errors = 0;
	int unsigned        tick_count = 0;
	int                 send_calm = 0;
	bit                 hold_req = 1'b0;

	coupled_exclusion_hop_step #(
		.SITES    (SITES),
		.REPLICAS (REPLICAS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		tick_count <= tick_count + 1;
		if (tick_count == RUN_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// advances the occupancy model by one word and returns the result bits
	function automatic logic [DATA_W-1:0] step_occupancy(op_t op, logic [PICK_W-1:0] pick,
			logic [FRAC_W-1:0] frac, logic [DATA_W-1:0] bits);
		int lane, site, dest, from_a, to_a;
		logic [DATA_W-1:0] src, dst, moved, osrc, odst;
		if (pick >= WORDS)
			return '0;
		lane = pick / SITES;
		site = pick % SITES;
		case (op)
			OP_HOP: begin
				if (lane == 0)
					dest = (site == SITES - 1) ? 0 : site + 1;
				else
					dest = (site == 0) ? SITES - 1 : site - 1;
				from_a = lane * SITES + site;
				to_a   = lane * SITES + dest;
				src    = lane_occ[from_a];
				dst    = lane_occ[to_a];
				moved  = src & ~dst & LIVE_MASK;
				if ({1'b0, frac} > gate_thr) begin
					osrc  = lane_occ[(1 - lane) * SITES + site];
					odst  = lane_occ[(1 - lane) * SITES + dest];
					moved &= ~(osrc & ~odst);
				end
				lane_occ[from_a] = src & ~moved;
				lane_occ[to_a]   = dst | moved;
				return moved;
			end
			OP_LOAD: begin
				lane_occ[pick] = bits & LIVE_MASK;
				return '0;
			end
			OP_READ: return lane_occ[pick];
			default: return '0;
		endcase
		return '0;
	endfunction

	// mostly traffic near the ring seam so hops see occupied neighbors
	function automatic hop_word_t random_word();
		hop_word_t w;
		int r, lane, site;
		logic [FRAC_W-1:0] edge_frac;
		w.lit  = 1'b0;
		w.want = '0;
		lane   = $urandom_range(0, 1);
		site   = RING_SEAM[$urandom_range(0, 4)];
		w.pick = PICK_W'(lane * SITES + site);
		if ($urandom_range(0, 99) < 15)
			w.pick = PICK_W'($urandom_range(0, WORDS - 1));
		r = $urandom_range(0, 99);
		w.op = (r < 25) ? OP_LOAD : (r < 80) ? OP_HOP : (r < 95) ? OP_READ : OP_NONE;
		w.bits = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1: w.bits &= {$urandom, $urandom};
			2, 3: w.bits |= {$urandom, $urandom};
			4: w.bits = '0;
			5: w.bits = '1;
			default: ;
		endcase
		edge_frac = (gate_thr > 17'hFFFF) ? 16'hFFFF : gate_thr[FRAC_W-1:0];
		r = $urandom_range(0, 99);
		if (r < 10)
			w.frac = edge_frac;
		else if (r < 20)
			w.frac = (edge_frac == 16'hFFFF) ? edge_frac : edge_frac + 16'd1;
		else if (r < 25)
			w.frac = '0;
		else if (r < 30)
			w.frac = '1;
		else
			w.frac = FRAC_W'($urandom);
		return w;
	endfunction

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic confirm_threshold();
		logic [PDATA_W-1:0] rd;
		apb_access(1'b0, ADDR_THRESHOLD, '0, rd);
		if (rd !== {{(PDATA_W - THR_W){1'b0}}, gate_thr}) begin
			$error("coupling_threshold: expected %h, actual %h", gate_thr, rd);
			errors++;
		end
	endtask

	task automatic offer_word(input hop_word_t w);
		logic [DATA_W-1:0] want;
		int gap;
		in_ch.valid           <= 1'b1;
		in_ch.operation       <= w.op;
		in_ch.site_pick       <= w.pick;
		in_ch.random_fraction <= w.frac;
		in_ch.load_bits       <= w.bits;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		want = step_occupancy(w.op, w.pick, w.frac, w.bits);
		if (w.lit)
			want = w.want;
		want_bits_q.push_back(want);
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else begin
			gap = idle_len();
			if ($urandom_range(0, 39) == 0)
				send_calm = $urandom_range(10, 30);
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: checks each word, then picks the next ready level
	initial begin
		int stall_left, calm_left, hold_left;
		logic [DATA_W-1:0] want;
		stall_left   = 0;
		calm_left    = 0;
		hold_left    = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (want_bits_q.size() == 0) begin
					$error("result_bits: no word expected, actual %h", out_ch.result_bits);
					errors++;
				end else begin
					want = want_bits_q.pop_front();
					if (out_ch.result_bits !== want) begin
						$error("result_bits: expected %h, actual %h", want,
							out_ch.result_bits);
						errors++;
					end
				end
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				out_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left = idle_len();
				if ($urandom_range(0, 199) == 0)
					calm_left = $urandom_range(30, 80);
			end
		end
	end

	initial begin
		logic [PDATA_W-1:0] rd;
		logic [THR_W-1:0] thr;
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		in_ch.valid           = 1'b0;
		in_ch.operation       = OP_NONE;
		in_ch.site_pick       = '0;
		in_ch.random_fraction = '0;
		in_ch.load_bits       = '0;
		gate_thr              = THR_RESET;
		foreach (lane_occ[i])
			lane_occ[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		confirm_threshold();

		foreach (WALK[i])
			offer_word(WALK[i]);

		for (int p = 0; p < PHASES; p++) begin
			in_ch.valid <= 1'b0;
			while (want_bits_q.size() != 0)
				@(posedge clk);
			if (p < 5)
				thr = THR_STEPS[p];
			else if (p == 5)
				thr = THR_W'($urandom_range(1, 65534));
			else
				thr = THR_W'($urandom_range(65537, 131070));
			apb_access(1'b1, ADDR_THRESHOLD, {{(PDATA_W - THR_W){1'b0}}, thr}, rd);
			gate_thr = thr;
			@(posedge clk);
			confirm_threshold();
			if (p == 0)
				hold_req = 1'b1;
			repeat (PHASE_WORDS) offer_word(random_word());
		end

		in_ch.valid <= 1'b0;
		while (want_bits_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* coupled_exclusion_hop_step.f */
rtl/core/ceh_pkg.sv
rtl/core/ceh_in_if.sv
rtl/core/ceh_out_if.sv
rtl/core/ceh_lane_ram.sv
rtl/core/coupled_exclusion_hop_step.sv
bench/coupled_exclusion_hop_step_tb.sv
